### rtl/ebpf_execute_unit_assert.svh
// assertion macros of the ebpf execute unit, used by the ebpf_ctrl module
`ifndef EBPF_EXECUTE_UNIT_ASSERT_SVH
`define EBPF_EXECUTE_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define EBPF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define EBPF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ebpf_pkg.sv
// shared types, codes and constants of the ebpf execute unit
`timescale 1ns / 1ps
package ebpf_pkg;

  localparam int NumRegsDef = 11;
  localparam int CtxReg     = 1;
  localparam int FrameReg   = 10;
  localparam int HalfBits   = 32;
  localparam int DivSteps   = 64;

  localparam int InW   = 160;
  localparam int OutW  = 88;
  localparam int CfgIw = 2;

  // register indexes of the configuration port
  localparam logic [CfgIw-1:0] CFG_BRANCH_LIMIT    = 2'd0;
  localparam logic [CfgIw-1:0] CFG_NO_BRANCH_LIMIT = 2'd1;
  localparam logic [CfgIw-1:0] CFG_STACK_TOP       = 2'd2;
  localparam logic [CfgIw-1:0] CFG_ALU32_ENABLE    = 2'd3;

  // opcode fields and fixed opcodes
  localparam logic [2:0] ClsAlu32 = 3'd4;
  localparam logic [2:0] ClsJmp   = 3'd5;
  localparam logic [2:0] ClsAlu64 = 3'd7;
  localparam logic [2:0] ClsLd    = 3'd1;
  localparam logic [2:0] ClsSt    = 3'd2;
  localparam logic [2:0] ClsStx   = 3'd3;
  localparam logic [2:0] ModeMem  = 3'd3;
  localparam logic [7:0] OpLddw   = 8'h18;
  localparam logic [7:0] OpExit   = 8'h95;
  localparam logic [7:0] OpJa     = 8'h05;
  localparam logic [7:0] OpCall   = 8'h85;
  localparam logic [7:0] OpLddwd  = 8'hB8;
  localparam logic [7:0] OpLddwr  = 8'hD8;

  typedef enum logic [2:0] {
    ST_CONT  = 3'd0,
    ST_RET   = 3'd1,
    ST_DIV0  = 3'd2,
    ST_NOBR  = 3'd3,
    ST_ILL   = 3'd4,
    ST_UNSUP = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    AOP_ADD  = 4'd0,
    AOP_SUB  = 4'd1,
    AOP_MUL  = 4'd2,
    AOP_DIV  = 4'd3,
    AOP_OR   = 4'd4,
    AOP_AND  = 4'd5,
    AOP_LSH  = 4'd6,
    AOP_RSH  = 4'd7,
    AOP_NEG  = 4'd8,
    AOP_MOD  = 4'd9,
    AOP_XOR  = 4'd10,
    AOP_MOV  = 4'd11,
    AOP_ARSH = 4'd12
  } aop_e;

  typedef enum logic [3:0] {
    JOP_JEQ  = 4'd1,
    JOP_JGT  = 4'd2,
    JOP_JGE  = 4'd3,
    JOP_JSET = 4'd4,
    JOP_JNE  = 4'd5,
    JOP_JSGT = 4'd6,
    JOP_JSGE = 4'd7,
    JOP_JLT  = 4'd10,
    JOP_JLE  = 4'd11,
    JOP_JSLT = 4'd12,
    JOP_JSLE = 4'd13
  } jop_e;

  typedef enum logic [3:0] {
    K_START,
    K_UNSUP,
    K_ILL,
    K_ALU,
    K_MUL,
    K_DIV,
    K_LDDW,
    K_RET,
    K_JUMP
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FRAME,
    S_MUL,
    S_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic wr_frame;
    logic mul_init;
    logic mul_step;
    logic div_init;
    logic div_step;
    logic finish;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  div_zero;
    logic  mul_done;
    logic  div_done;
    logic  out_busy;
  } stat_t;

endpackage

### rtl/ebpf_ctrl.sv
// sequencing state machine of the ebpf execute unit
`timescale 1ns / 1ps
`include "ebpf_execute_unit_assert.svh"
module ebpf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  input  ebpf_pkg::stat_t stat_i,
  output ebpf_pkg::cmd_t  cmd_o
);

  ebpf_pkg::state_e state_q, state_d;
  logic accept;

  assign s_tready_o = (state_q == ebpf_pkg::S_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ebpf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ebpf_pkg::S_IDLE: begin
        if (accept) state_d = ebpf_pkg::S_EXEC;
      end
      ebpf_pkg::S_EXEC: begin
        case (stat_i.kind)
          ebpf_pkg::K_START: state_d = ebpf_pkg::S_FRAME;
          ebpf_pkg::K_MUL:   state_d = ebpf_pkg::S_MUL;
          ebpf_pkg::K_DIV:   state_d = stat_i.div_zero ? ebpf_pkg::S_DONE : ebpf_pkg::S_DIV;
          default:           state_d = ebpf_pkg::S_DONE;
        endcase
      end
      ebpf_pkg::S_FRAME: state_d = ebpf_pkg::S_DONE;
      ebpf_pkg::S_MUL: begin
        if (stat_i.mul_done) state_d = ebpf_pkg::S_DONE;
      end
      ebpf_pkg::S_DIV: begin
        if (stat_i.div_done) state_d = ebpf_pkg::S_DONE;
      end
      ebpf_pkg::S_DONE: begin
        if (!stat_i.out_busy) state_d = ebpf_pkg::S_IDLE;
      end
      default: state_d = ebpf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ebpf_pkg::S_IDLE: cmd_o.load = accept;
      ebpf_pkg::S_EXEC: begin
        case (stat_i.kind)
          ebpf_pkg::K_START: cmd_o.start = 1'b1;
          ebpf_pkg::K_MUL:   cmd_o.mul_init = 1'b1;
          ebpf_pkg::K_DIV: begin
            cmd_o.div_init = !stat_i.div_zero;
            cmd_o.finish   = stat_i.div_zero;
          end
          default: cmd_o.finish = 1'b1;
        endcase
      end
      ebpf_pkg::S_FRAME: cmd_o.wr_frame = 1'b1;
      ebpf_pkg::S_MUL: begin
        cmd_o.mul_step = !stat_i.mul_done;
        cmd_o.finish   = stat_i.mul_done;
      end
      ebpf_pkg::S_DIV: begin
        cmd_o.div_step = !stat_i.div_done;
        cmd_o.finish   = stat_i.div_done;
      end
      ebpf_pkg::S_DONE: cmd_o.out_load = !stat_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

  `EBPF_ASSERT_NXT(a_accept_exec, clk_i, rst_ni, accept, state_q == ebpf_pkg::S_EXEC, "accepted word did not reach execute")
  `EBPF_ASSERT_IMP(a_out_free, clk_i, rst_ni, cmd_o.out_load, !stat_i.out_busy, "result loaded over a waiting word")
  `EBPF_ASSERT_NXT(a_mul_done, clk_i, rst_ni, state_q == ebpf_pkg::S_MUL && stat_i.mul_done, state_q == ebpf_pkg::S_DONE, "multiply did not finish")

endmodule

### rtl/ebpf_dpath.sv
// register file, alu, multiplier, divider and result register of the ebpf execute unit
`timescale 1ns / 1ps
module ebpf_dpath #(
  parameter int NUM_REGS = ebpf_pkg::NumRegsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [ebpf_pkg::InW-1:0] s_tdata_i,
  input  logic                     s_tuser_i,
  input  logic                     cfg_we_i,
  input  logic [ebpf_pkg::CfgIw-1:0] cfg_idx_i,
  input  logic [63:0]              cfg_data_i,
  input  ebpf_pkg::cmd_t           cmd_i,
  output ebpf_pkg::stat_t          stat_o,
  output logic                     m_tvalid_o,
  input  logic                     m_tready_i,
  output logic [ebpf_pkg::OutW-1:0] m_tdata_o
);

  localparam int RegAw = $clog2(NUM_REGS);
  localparam int CntW  = $clog2(ebpf_pkg::DivSteps + 1);

  // configuration
  logic [15:0] limit_q;
  logic        nolimit_q;
  logic [63:0] stack_q;
  logic        alu32_q;
  logic [15:0] budget_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= 16'd1000;
      nolimit_q <= 1'b0;
      stack_q   <= '0;
      alu32_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ebpf_pkg::CFG_BRANCH_LIMIT:    limit_q   <= cfg_data_i[15:0];
        ebpf_pkg::CFG_NO_BRANCH_LIMIT: nolimit_q <= cfg_data_i[0];
        ebpf_pkg::CFG_STACK_TOP:       stack_q   <= cfg_data_i;
        ebpf_pkg::CFG_ALU32_ENABLE:    alu32_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // latched item
  logic        func_q;
  logic [7:0]  op_q;
  logic [3:0]  dst_q, src_q;
  logic [15:0] off_q;
  logic [31:0] imm_q, immh_q;
  logic [63:0] ctx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= s_tuser_i;
      op_q   <= s_tdata_i[7:0];
      dst_q  <= s_tdata_i[11:8];
      src_q  <= s_tdata_i[15:12];
      off_q  <= s_tdata_i[31:16];
      imm_q  <= s_tdata_i[63:32];
      immh_q <= s_tdata_i[95:64];
      ctx_q  <= s_tdata_i[159:96];
    end
  end

  // register file with registered reads, valid bits mark written entries, the others read as zero
  logic [63:0]         mem_q [NUM_REGS];
  logic [NUM_REGS-1:0] valid_q;
  logic [63:0]         rda_q, rdb_q;
  logic                va_q, vb_q;
  logic [63:0]         r0_q;
  logic                wr_en;
  logic [RegAw-1:0]    wr_addr;
  logic [63:0]         wr_data;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rda_q <= mem_q[s_tdata_i[8 +: RegAw]];
      rdb_q <= mem_q[s_tdata_i[12 +: RegAw]];
    end
    if (wr_en) mem_q[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      r0_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        va_q <= valid_q[s_tdata_i[8 +: RegAw]];
        vb_q <= valid_q[s_tdata_i[12 +: RegAw]];
      end
      if (cmd_i.start) begin
        // only the context register holds data after a start
        valid_q <= NUM_REGS'(1) << ebpf_pkg::CtxReg;
        r0_q <= '0;
      end else if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
        if (wr_addr == '0) r0_q <= wr_data;
      end
    end
  end

  // operands
  logic        wide, x;
  logic [3:0]  hi;
  logic [63:0] a, b, imm64, a_n, b_n;
  logic [5:0]  sh;

  assign wide  = (op_q[2:0] == ebpf_pkg::ClsAlu64);
  assign x     = op_q[3];
  assign hi    = op_q[7:4];
  assign imm64 = {{32{imm_q[31]}}, imm_q};
  assign a     = va_q ? rda_q : '0;
  assign b     = x ? (vb_q ? rdb_q : '0) : imm64;
  assign a_n   = wide ? a : {32'd0, a[31:0]};
  assign b_n   = wide ? b : {32'd0, b[31:0]};
  assign sh    = wide ? b_n[5:0] : {1'b0, b_n[4:0]};

  // combinational alu operations
  logic [63:0] v, arsh_src, alu_res;
  always_comb begin
    arsh_src = wide ? a_n : {{32{a_n[31]}}, a_n[31:0]};
    case (ebpf_pkg::aop_e'(hi))
      ebpf_pkg::AOP_ADD:  v = a_n + b_n;
      ebpf_pkg::AOP_SUB:  v = a_n - b_n;
      ebpf_pkg::AOP_OR:   v = a_n | b_n;
      ebpf_pkg::AOP_AND:  v = a_n & b_n;
      ebpf_pkg::AOP_LSH:  v = a_n << sh;
      ebpf_pkg::AOP_RSH:  v = a_n >> sh;
      ebpf_pkg::AOP_NEG:  v = 64'd0 - a_n;
      ebpf_pkg::AOP_XOR:  v = a_n ^ b_n;
      ebpf_pkg::AOP_MOV:  v = b_n;
      ebpf_pkg::AOP_ARSH: v = $unsigned($signed(arsh_src) >>> sh);
      default:            v = b_n;
    endcase
  end
  assign alu_res = wide ? v : {32'd0, v[31:0]};

  // jump condition, signed compares flip the sign bit
  logic [63:0] sa, sb;
  logic        cond, taken;
  assign sa = a ^ {1'b1, 63'd0};
  assign sb = b ^ {1'b1, 63'd0};
  always_comb begin
    case (ebpf_pkg::jop_e'(hi))
      ebpf_pkg::JOP_JEQ:  cond = (a == b);
      ebpf_pkg::JOP_JGT:  cond = (a > b);
      ebpf_pkg::JOP_JGE:  cond = (a >= b);
      ebpf_pkg::JOP_JSET: cond = ((a & b) != '0);
      ebpf_pkg::JOP_JNE:  cond = (a != b);
      ebpf_pkg::JOP_JSGT: cond = (sa > sb);
      ebpf_pkg::JOP_JSGE: cond = (sa >= sb);
      ebpf_pkg::JOP_JLT:  cond = (a < b);
      ebpf_pkg::JOP_JLE:  cond = (a <= b);
      ebpf_pkg::JOP_JSLT: cond = (sa < sb);
      default:            cond = (sa <= sb);
    endcase
  end
  assign taken = (op_q == ebpf_pkg::OpJa) || cond;

  // decode
  logic             dst_bad, src_bad, is_mem;
  ebpf_pkg::kind_e  kind;
  assign dst_bad = ({1'b0, dst_q} >= 5'(NUM_REGS));
  assign src_bad = x && ({1'b0, src_q} >= 5'(NUM_REGS));
  assign is_mem  = (op_q == ebpf_pkg::OpLddwd) || (op_q == ebpf_pkg::OpLddwr) ||
                   (op_q == ebpf_pkg::OpCall) ||
                   ((op_q[7:5] == ebpf_pkg::ModeMem) &&
                    ((op_q[2:0] == ebpf_pkg::ClsLd) || (op_q[2:0] == ebpf_pkg::ClsSt) ||
                     (op_q[2:0] == ebpf_pkg::ClsStx)));

  always_comb begin
    if (func_q) begin
      kind = ebpf_pkg::K_START;
    end else if (is_mem) begin
      kind = ebpf_pkg::K_UNSUP;
    end else if (op_q[2:0] == ebpf_pkg::ClsAlu64 || op_q[2:0] == ebpf_pkg::ClsAlu32) begin
      if (hi > 4'd12 || (hi == ebpf_pkg::AOP_NEG && x) || (!wide && !alu32_q) ||
          dst_bad || src_bad) begin
        kind = ebpf_pkg::K_ILL;
      end else if (hi == ebpf_pkg::AOP_MUL) begin
        kind = ebpf_pkg::K_MUL;
      end else if (hi == ebpf_pkg::AOP_DIV || hi == ebpf_pkg::AOP_MOD) begin
        kind = ebpf_pkg::K_DIV;
      end else begin
        kind = ebpf_pkg::K_ALU;
      end
    end else if (op_q == ebpf_pkg::OpLddw) begin
      kind = dst_bad ? ebpf_pkg::K_ILL : ebpf_pkg::K_LDDW;
    end else if (op_q == ebpf_pkg::OpExit) begin
      kind = ebpf_pkg::K_RET;
    end else if (op_q == ebpf_pkg::OpJa) begin
      kind = ebpf_pkg::K_JUMP;
    end else if (op_q[2:0] == ebpf_pkg::ClsJmp &&
                 ((hi >= 4'd1 && hi <= 4'd7) || (hi >= 4'd10 && hi <= 4'd13))) begin
      kind = (dst_bad || src_bad) ? ebpf_pkg::K_ILL : ebpf_pkg::K_JUMP;
    end else begin
      kind = ebpf_pkg::K_ILL;
    end
  end

  // shared operand registers, one 32x32 product per cycle
  logic [63:0] opa_q, opb_q, prod_q, acc_q;
  logic [2:0]  mul_cnt_q;
  logic [31:0] mx, my;
  assign mx = (mul_cnt_q == 3'd2) ? opa_q[63:32] : opa_q[31:0];
  assign my = (mul_cnt_q == 3'd1) ? opb_q[63:32] : opb_q[31:0];

  // restoring divider, one quotient bit per cycle
  logic [63:0]   quo_q, rem_q;
  logic [CntW-1:0] div_cnt_q;
  logic [64:0]   trial;
  logic          fits;
  assign trial = {rem_q, quo_q[63]};
  assign fits  = (trial >= {1'b0, opb_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_init || cmd_i.div_init) begin
      opa_q <= a_n;
      opb_q <= b_n;
    end
    if (cmd_i.mul_step) begin
      prod_q <= 64'(mx) * 64'(my);
      case (mul_cnt_q)
        3'd1:    acc_q <= prod_q;
        3'd2:    acc_q <= acc_q + {prod_q[31:0], 32'd0};
        3'd3:    acc_q <= acc_q + {prod_q[31:0], 32'd0};
        default: acc_q <= acc_q;
      endcase
    end
    if (cmd_i.div_init) begin
      quo_q <= a_n;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[62:0], fits};
      rem_q <= fits ? 64'(trial - {1'b0, opb_q}) : trial[63:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_cnt_q <= '0;
      div_cnt_q <= '0;
    end else begin
      if (cmd_i.mul_init) mul_cnt_q <= '0;
      else if (cmd_i.mul_step) mul_cnt_q <= mul_cnt_q + 3'd1;
      if (cmd_i.div_init) div_cnt_q <= '0;
      else if (cmd_i.div_step) div_cnt_q <= div_cnt_q + CntW'(1);
    end
  end

  // result of the item
  ebpf_pkg::status_e st;
  logic [15:0] budget_dec;
  logic [63:0] res_val, mul_res, div_res;
  logic        writes;
  assign budget_dec = budget_q - 16'd1;
  assign mul_res    = wide ? acc_q : {32'd0, acc_q[31:0]};
  assign div_res    = (hi == ebpf_pkg::AOP_DIV) ? quo_q : rem_q;

  always_comb begin
    case (kind)
      ebpf_pkg::K_UNSUP: st = ebpf_pkg::ST_UNSUP;
      ebpf_pkg::K_ILL:   st = ebpf_pkg::ST_ILL;
      ebpf_pkg::K_RET:   st = ebpf_pkg::ST_RET;
      ebpf_pkg::K_DIV:   st = stat_o.div_zero ? ebpf_pkg::ST_DIV0 : ebpf_pkg::ST_CONT;
      ebpf_pkg::K_JUMP:  st = (taken && !nolimit_q && budget_dec == '0) ?
                              ebpf_pkg::ST_NOBR : ebpf_pkg::ST_CONT;
      default:           st = ebpf_pkg::ST_CONT;
    endcase
    case (kind)
      ebpf_pkg::K_MUL:  res_val = mul_res;
      ebpf_pkg::K_DIV:  res_val = wide ? div_res : {32'd0, div_res[31:0]};
      ebpf_pkg::K_LDDW: res_val = {immh_q, imm_q};
      default:          res_val = alu_res;
    endcase
  end

  assign writes = (kind == ebpf_pkg::K_ALU) || (kind == ebpf_pkg::K_MUL) ||
                  (kind == ebpf_pkg::K_DIV) || (kind == ebpf_pkg::K_LDDW);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = dst_q[RegAw-1:0];
    wr_data = res_val;
    if (cmd_i.start) begin
      wr_en   = 1'b1;
      wr_addr = RegAw'(ebpf_pkg::CtxReg);
      wr_data = ctx_q;
    end else if (cmd_i.wr_frame) begin
      wr_en   = 1'b1;
      wr_addr = RegAw'(ebpf_pkg::FrameReg);
      wr_data = stack_q;
    end else if (cmd_i.finish && writes && st == ebpf_pkg::ST_CONT) begin
      wr_en = 1'b1;
    end
  end

  ebpf_pkg::status_e res_st_q;
  logic [16:0]       res_adv_q;
  logic              m_tvalid_q;
  logic [ebpf_pkg::OutW-1:0] m_tdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      res_st_q  <= ebpf_pkg::ST_CONT;
      res_adv_q <= '0;
    end else if (cmd_i.finish) begin
      res_st_q <= st;
      if (st != ebpf_pkg::ST_CONT) res_adv_q <= '0;
      else if (kind == ebpf_pkg::K_LDDW) res_adv_q <= 17'd2;
      else if (kind == ebpf_pkg::K_JUMP && taken) res_adv_q <= {off_q[15], off_q} + 17'd1;
      else res_adv_q <= 17'd1;
    end
    if (cmd_i.out_load) begin
      m_tdata_q <= {4'd0, r0_q, res_adv_q, res_st_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q   <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      if (cmd_i.start) budget_q <= limit_q;
      else if (cmd_i.finish && kind == ebpf_pkg::K_JUMP && taken) budget_q <= budget_dec;
      if (cmd_i.out_load) m_tvalid_q <= 1'b1;
      else if (m_tready_i) m_tvalid_q <= 1'b0;
    end
  end

  assign m_tvalid_o      = m_tvalid_q;
  assign m_tdata_o       = m_tdata_q;
  assign stat_o.kind     = kind;
  assign stat_o.div_zero = (b_n == '0);
  assign stat_o.mul_done = (mul_cnt_q == 3'd4);
  assign stat_o.div_done = (div_cnt_q == CntW'(ebpf_pkg::DivSteps));
  assign stat_o.out_busy = m_tvalid_q && !m_tready_i;

endmodule

### rtl/ebpf_execute_unit.sv
// top level of the ebpf execute unit
//
//  channel   direction  handshake            contents
//  s_*       in         s_tvalid/s_tready    one instruction word (or a start word)
//  m_*       out        m_tvalid/m_tready    status, pc advance and r0 per word
//  cfg_*     in         cfg_we               branch limit, limit off, stack top, alu32 on
//
// one word is in flight at a time: accept, execute, then hand the result to the output
// register; a start word writes the frame register between execute and the hand-over
// multiply runs the shared 32x32 multiplier for 4 steps plus a finish step
// div and mod step the restoring divider one bit a cycle; a zero divisor skips the divider
// a new word is taken while the previous result still waits in the output register;
// a stalled output holds its word and the next result waits for it to be taken
// reset clears state machine, valid bits of the register file and the branch budget
`timescale 1ns / 1ps
module ebpf_execute_unit #(
  parameter int NUM_REGS = ebpf_pkg::NumRegsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_tvalid_i,
  output logic                       s_tready_o,
  // opcode[7:0], dst_reg[11:8], src_reg[15:12], offset[31:16], immediate[63:32],
  // immediate_high[95:64], context_value[159:96]
  input  logic [ebpf_pkg::InW-1:0]   s_tdata_i,
  // func: 0 execute, 1 start a new run
  input  logic                       s_tuser_i,
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  // status[2:0], pc_advance[19:3], return_value[83:20], zero pad above
  output logic [ebpf_pkg::OutW-1:0]  m_tdata_o,
  input  logic                       cfg_we_i,
  input  logic [ebpf_pkg::CfgIw-1:0] cfg_idx_i,
  input  logic [63:0]                cfg_data_i
);

  // commands down, status up
  ebpf_pkg::cmd_t  cmd;
  ebpf_pkg::stat_t stat;

  ebpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ebpf_dpath #(
    .NUM_REGS (NUM_REGS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

endmodule

### dv/testbench.sv
// self-checking testbench of the ebpf execute unit with its own instruction predictor
`timescale 1ns / 1ps
module testbench;

  localparam int NRegs = ebpf_pkg::NumRegsDef;
  localparam int LimitCycles = 400000;

  typedef struct packed {
    logic        func;
    logic [7:0]  opcode;
    logic [3:0]  dst;
    logic [3:0]  src;
    logic [15:0] offset;
    logic [31:0] imm;
    logic [31:0] imm_hi;
    logic [63:0] ctx;
  } instr_t;

  typedef struct packed {
    ebpf_pkg::status_e status;
    logic [16:0]       adv;
    logic [63:0]       r0;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid_i = 1'b0;
  logic s_tready_o;
  logic [ebpf_pkg::InW-1:0] s_tdata_i = '0;
  logic s_tuser_i = 1'b0;
  logic m_tvalid_o;
  logic m_tready_i = 1'b0;
  logic [ebpf_pkg::OutW-1:0] m_tdata_o;
  logic cfg_we_i = 1'b0;
  logic [ebpf_pkg::CfgIw-1:0] cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;

  // predictor state and configuration shadow
  logic [63:0] regs [NRegs];
  logic [15:0] budget;
  logic [15:0] lim_q;
  logic        nolim_q;
  logic [63:0] stack_q;
  logic        a32_q;

  instr_t   pending_words [$];
  outcome_t expected_outcomes [$];
  int       errors = 0;
  int       cycles = 0;
  bit       pause_req = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;

  always #1 clk_i = ~clk_i;

  ebpf_execute_unit dut (.*);

  // sign extension of a 32-bit value to 64 bits
  function automatic logic [63:0] sext32(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic bit branch_taken(logic [3:0] jop, logic [63:0] a, logic [63:0] b);
    case (jop)
      ebpf_pkg::JOP_JEQ:  return a == b;
      ebpf_pkg::JOP_JGT:  return a > b;
      ebpf_pkg::JOP_JGE:  return a >= b;
      ebpf_pkg::JOP_JSET: return (a & b) != 0;
      ebpf_pkg::JOP_JNE:  return a != b;
      ebpf_pkg::JOP_JSGT: return $signed(a) > $signed(b);
      ebpf_pkg::JOP_JSGE: return $signed(a) >= $signed(b);
      ebpf_pkg::JOP_JLT:  return a < b;
      ebpf_pkg::JOP_JLE:  return a <= b;
      ebpf_pkg::JOP_JSLT: return $signed(a) < $signed(b);
      default:            return $signed(a) <= $signed(b);
    endcase
  endfunction

  // runs one word through the predictor and returns its outcome
  function automatic outcome_t execute_word(instr_t w);
    outcome_t o;
    logic [2:0]  cls;
    logic [3:0]  hi;
    logic        x, wide, taken;
    logic [63:0] a, b, v;
    logic [5:0]  sh;
    cls = w.opcode[2:0];
    hi = w.opcode[7:4];
    x = w.opcode[3];
    o.status = ebpf_pkg::ST_CONT;
    o.adv = 17'd1;
    if (w.func) begin
      for (int i = 0; i < NRegs; i++) regs[i] = '0;
      regs[ebpf_pkg::CtxReg] = w.ctx;
      regs[ebpf_pkg::FrameReg] = stack_q;
      budget = lim_q;
      o.adv = '0;
    end else if (w.opcode == ebpf_pkg::OpLddwd || w.opcode == ebpf_pkg::OpLddwr ||
                 w.opcode == ebpf_pkg::OpCall ||
                 (w.opcode[7:5] == ebpf_pkg::ModeMem &&
                  (cls == ebpf_pkg::ClsLd || cls == ebpf_pkg::ClsSt || cls == ebpf_pkg::ClsStx)))
    begin
      o.status = ebpf_pkg::ST_UNSUP;
    end else if (cls == ebpf_pkg::ClsAlu64 || cls == ebpf_pkg::ClsAlu32) begin
      wide = (cls == ebpf_pkg::ClsAlu64);
      if (hi > 4'd12 || (hi == ebpf_pkg::AOP_NEG && x) || (!wide && !a32_q) ||
          w.dst >= NRegs || (x && w.src >= NRegs)) begin
        o.status = ebpf_pkg::ST_ILL;
      end else begin
        a = regs[w.dst];
        b = x ? regs[w.src] : sext32(w.imm);
        if (!wide) begin
          a = {32'd0, a[31:0]};
          b = {32'd0, b[31:0]};
        end
        sh = wide ? b[5:0] : {1'b0, b[4:0]};
        case (ebpf_pkg::aop_e'(hi))
          ebpf_pkg::AOP_ADD:  v = a + b;
          ebpf_pkg::AOP_SUB:  v = a - b;
          ebpf_pkg::AOP_MUL:  v = a * b;
          ebpf_pkg::AOP_DIV:  v = (b == 0) ? '0 : a / b;
          ebpf_pkg::AOP_OR:   v = a | b;
          ebpf_pkg::AOP_AND:  v = a & b;
          ebpf_pkg::AOP_LSH:  v = a << sh;
          ebpf_pkg::AOP_RSH:  v = a >> sh;
          ebpf_pkg::AOP_NEG:  v = 64'd0 - a;
          ebpf_pkg::AOP_MOD:  v = (b == 0) ? '0 : a % b;
          ebpf_pkg::AOP_XOR:  v = a ^ b;
          ebpf_pkg::AOP_MOV:  v = b;
          default:            v = $signed(wide ? a : sext32(a[31:0])) >>> sh;
        endcase
        if ((hi == ebpf_pkg::AOP_DIV || hi == ebpf_pkg::AOP_MOD) && b == 0)
          o.status = ebpf_pkg::ST_DIV0;
        else regs[w.dst] = wide ? v : {32'd0, v[31:0]};
      end
    end else if (w.opcode == ebpf_pkg::OpLddw) begin
      if (w.dst >= NRegs) o.status = ebpf_pkg::ST_ILL;
      else begin
        regs[w.dst] = {w.imm_hi, w.imm};
        o.adv = 17'd2;
      end
    end else if (w.opcode == ebpf_pkg::OpExit) begin
      o.status = ebpf_pkg::ST_RET;
    end else if (cls == ebpf_pkg::ClsJmp && (w.opcode == ebpf_pkg::OpJa ||
                 (hi >= 1 && hi <= 7) || (hi >= 10 && hi <= 13))) begin
      taken = 1'b1;
      if (w.opcode != ebpf_pkg::OpJa) begin
        if (w.dst >= NRegs || (x && w.src >= NRegs)) o.status = ebpf_pkg::ST_ILL;
        else taken = branch_taken(hi, regs[w.dst], x ? regs[w.src] : sext32(w.imm));
      end
      if (o.status == ebpf_pkg::ST_CONT && taken) begin
        budget = budget - 16'd1;
        if (!nolim_q && budget == 0) o.status = ebpf_pkg::ST_NOBR;
        else o.adv = {w.offset[15], w.offset} + 17'd1;
      end
    end else begin
      o.status = ebpf_pkg::ST_ILL;
    end
    if (o.status != ebpf_pkg::ST_CONT) o.adv = '0;
    o.r0 = regs[0];
    return o;
  endfunction

  function automatic instr_t make_word(logic [7:0] op, logic [3:0] d, logic [3:0] s,
                                       logic [15:0] off, logic [31:0] imm);
    instr_t w;
    w.func = 1'b0;
    w.opcode = op;
    w.dst = d;
    w.src = s;
    w.offset = off;
    w.imm = imm;
    w.imm_hi = $urandom;
    w.ctx = {$urandom, $urandom};
    return w;
  endfunction

  function automatic instr_t start_word(logic [63:0] ctx);
    instr_t w;
    w = make_word(8'h00, 4'd0, 4'd0, 16'd0, 32'd0);
    w.func = 1'b1;
    w.ctx = ctx;
    return w;
  endfunction

  // mostly well-formed alu and jump words, some noise
  function automatic instr_t random_word();
    logic [7:0] op;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      op = {4'($urandom_range(0, 12)), 1'($urandom),
            ($urandom_range(0, 3) == 0) ? ebpf_pkg::ClsAlu32 : ebpf_pkg::ClsAlu64};
      if (op[7:4] == ebpf_pkg::AOP_DIV || op[7:4] == ebpf_pkg::AOP_MOD)
        if ($urandom_range(0, 2) != 0) op[7:4] = ebpf_pkg::AOP_XOR;
    end else if (sel < 70) begin
      op = {4'($urandom_range(0, 1) ? $urandom_range(1, 7) : $urandom_range(10, 13)),
            1'($urandom), ebpf_pkg::ClsJmp};
    end else if (sel < 77) op = ebpf_pkg::OpLddw;
    else if (sel < 80) op = ebpf_pkg::OpExit;
    else if (sel < 83) op = ebpf_pkg::OpJa;
    else op = 8'($urandom);
    return make_word(op, ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 10)),
                     ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 10)),
                     16'($urandom),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70) : $urandom);
  endfunction

  // sender: bursts with random gaps, halts while a drain is requested
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_o) begin
        expected_outcomes.push_back(execute_word(pending_words.pop_front()));
      end
      if (s_tvalid_i && !s_tready_o) begin
        // hold the word until taken
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid_i <= 1'b0;
      end else if (pending_words.size() > 0 && !pause_req) begin
        s_tdata_i <= {pending_words[0].ctx, pending_words[0].imm_hi, pending_words[0].imm,
                      pending_words[0].offset, pending_words[0].src, pending_words[0].dst,
                      pending_words[0].opcode};
        s_tuser_i <= pending_words[0].func;
        s_tvalid_i <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver: stall pattern alternates between stretches of always ready and random
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t unexpected word: actual %h", $realtime, m_tdata_o);
          errors <= errors + 1;
        end else begin
          outcome_t e;
          e = expected_outcomes.pop_front();
          if (m_tdata_o[2:0] != e.status || m_tdata_o[19:3] != e.adv ||
              m_tdata_o[83:20] != e.r0) begin
            $display("%0t mismatch: expected status %0d adv %h r0 %h, actual status %0d adv %h r0 %h",
                     $realtime, e.status, e.adv, e.r0, m_tdata_o[2:0], m_tdata_o[19:3],
                     m_tdata_o[83:20]);
            errors <= errors + 1;
          end
        end
      end
      m_tready_i <= (cycles[9:8] == 2'b01) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
    if (cycles > LimitCycles) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [ebpf_pkg::CfgIw-1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ebpf_pkg::CFG_BRANCH_LIMIT:    lim_q = val[15:0];
      ebpf_pkg::CFG_NO_BRANCH_LIMIT: nolim_q = val[0];
      ebpf_pkg::CFG_STACK_TOP:       stack_q = val;
      ebpf_pkg::CFG_ALU32_ENABLE:    a32_q = val[0];
      default: ;
    endcase
  endtask

  // waits until every queued word went through and the block is quiet
  task automatic drain();
    wait (pending_words.size() == 0);
    pause_req = 1'b1;
    wait (expected_outcomes.size() == 0);
    repeat (100) @(posedge clk_i);
    pause_req = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NRegs; i++) regs[i] = '0;
    budget = '0;
    lim_q = 16'd1000;
    nolim_q = 1'b0;
    stack_q = '0;
    a32_q = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(ebpf_pkg::CFG_STACK_TOP, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(ebpf_pkg::CFG_BRANCH_LIMIT, 64'd3);
    // directed: extremes, division by zero, alu32 neg and arsh, budget abort, odd opcodes
    pending_words.push_back(start_word(64'h8000_0000_0000_0001));
    pending_words.push_back(make_word(ebpf_pkg::OpLddw, 4'd0, 4'd0, 16'd0, 32'h8000_0000));
    pending_words.push_back(make_word({ebpf_pkg::AOP_NEG, 1'b0, ebpf_pkg::ClsAlu32},
                                      4'd0, 4'd0, 16'd0, 32'd0));
    pending_words.push_back(make_word({ebpf_pkg::AOP_ARSH, 1'b0, ebpf_pkg::ClsAlu32},
                                      4'd1, 4'd0, 16'd0, 32'd35));
    pending_words.push_back(make_word({ebpf_pkg::AOP_ARSH, 1'b1, ebpf_pkg::ClsAlu64},
                                      4'd10, 4'd1, 16'd0, 32'd0));
    pending_words.push_back(make_word({ebpf_pkg::AOP_DIV, 1'b0, ebpf_pkg::ClsAlu64},
                                      4'd0, 4'd0, 16'd0, 32'd0));
    pending_words.push_back(make_word({ebpf_pkg::AOP_MOD, 1'b1, ebpf_pkg::ClsAlu32},
                                      4'd0, 4'd2, 16'd0, 32'd0));
    pending_words.push_back(make_word({ebpf_pkg::AOP_DIV, 1'b1, ebpf_pkg::ClsAlu64},
                                      4'd10, 4'd1, 16'd0, 32'd0));
    pending_words.push_back(make_word({ebpf_pkg::AOP_MUL, 1'b0, ebpf_pkg::ClsAlu64},
                                      4'd10, 4'd0, 16'd0, 32'hFFFF_FFFF));
    pending_words.push_back(make_word({ebpf_pkg::AOP_NEG, 1'b1, ebpf_pkg::ClsAlu64},
                                      4'd0, 4'd0, 16'd0, 32'd0));
    pending_words.push_back(make_word({ebpf_pkg::AOP_ADD, 1'b1, ebpf_pkg::ClsAlu64},
                                      4'd15, 4'd0, 16'd0, 32'd0));
    pending_words.push_back(make_word({ebpf_pkg::AOP_ADD, 1'b1, ebpf_pkg::ClsAlu64},
                                      4'd0, 4'd11, 16'd0, 32'd0));
    pending_words.push_back(make_word(8'hD5, 4'd0, 4'd0, 16'd0, 32'd0));
    pending_words.push_back(make_word(8'h61, 4'd15, 4'd15, 16'd0, 32'd0));
    pending_words.push_back(make_word(ebpf_pkg::OpCall, 4'd0, 4'd0, 16'd0, 32'd0));
    pending_words.push_back(make_word(ebpf_pkg::OpLddwd, 4'd0, 4'd0, 16'd0, 32'd0));
    pending_words.push_back(make_word(ebpf_pkg::OpLddwr, 4'd0, 4'd0, 16'd0, 32'd0));
    pending_words.push_back(make_word(ebpf_pkg::OpJa, 4'd15, 4'd15, 16'h7FFF, 32'd0));
    pending_words.push_back(make_word(ebpf_pkg::OpJa, 4'd0, 4'd0, 16'h8000, 32'd0));
    pending_words.push_back(make_word(ebpf_pkg::OpJa, 4'd0, 4'd0, 16'h0000, 32'd0));
    pending_words.push_back(make_word(ebpf_pkg::OpExit, 4'd0, 4'd0, 16'd0, 32'd0));
    pending_words.push_back(make_word(8'hFF, 4'd0, 4'd0, 16'hFFFF, 32'hFFFF_FFFF));
    drain();

    write_reg(ebpf_pkg::CFG_ALU32_ENABLE, 64'd0);
    write_reg(ebpf_pkg::CFG_BRANCH_LIMIT, 64'd0);
    pending_words.push_back(make_word({ebpf_pkg::AOP_ADD, 1'b0, ebpf_pkg::ClsAlu32},
                                      4'd0, 4'd0, 16'd0, 32'd1));
    pending_words.push_back(start_word(64'd0));
    pending_words.push_back(make_word(ebpf_pkg::OpJa, 4'd0, 4'd0, 16'd5, 32'd0));
    for (int i = 0; i < 150; i++) pending_words.push_back(random_word());
    drain();

    write_reg(ebpf_pkg::CFG_ALU32_ENABLE, 64'd1);
    write_reg(ebpf_pkg::CFG_NO_BRANCH_LIMIT, 64'd1);
    write_reg(ebpf_pkg::CFG_BRANCH_LIMIT, 64'hFFFF);
    write_reg(ebpf_pkg::CFG_STACK_TOP, 64'd0);
    pending_words.push_back(start_word({$urandom, $urandom}));
    for (int i = 0; i < 200; i++) pending_words.push_back(random_word());
    drain();

    write_reg(ebpf_pkg::CFG_NO_BRANCH_LIMIT, 64'd0);
    write_reg(ebpf_pkg::CFG_BRANCH_LIMIT, 64'd40);
    write_reg(ebpf_pkg::CFG_STACK_TOP, {$urandom, $urandom});
    for (int i = 0; i < 200; i++) begin
      if ($urandom_range(0, 40) == 0) pending_words.push_back(start_word({$urandom, $urandom}));
      else pending_words.push_back(random_word());
    end
    drain();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
